@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the task switch scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TSS_NUM_TASKS = 8;

    localparam int TSS_OP_W   = 2;
    localparam int TSS_WORD_W = 32;
    localparam int TSS_TGT_W  = 3;
    localparam int TSS_CUR_W  = 3;

    typedef enum logic [TSS_OP_W-1:0] {
        OP_SWITCH    = 2'd0,
        OP_WAIT      = 2'd1,
        OP_ACTIVATE  = 2'd2,
        OP_SET_STATE = 2'd3
    } t_op;

endpackage

@@ rtl/task_switch_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// task_switch_scheduler_top
// Non-wrapping task scheduler with an idle task, one task slot tested per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op plus its operand fields) is taken at a clock edge where start
//   is high and busy is low. busy stays high while the op is worked on. The
//   result (current task, stack pointer, wakeup reason) is shown for exactly
//   one cycle with o_done high; the receiver cannot stall it.
// Steps, from the accepting edge to the result: set_state and an activate
//   that is dropped (killed or out of range target) finish in the exec state,
//   wait and any other activate pass through exec and load, and switch passes
//   through exec, the scan and load; the scan visits k task slots, with k in
//   1 .. NUM_TASKS. The scan tests one slot per cycle against the ready
//   and killed flags, and each per-task word store has one write and one
//   registered read port, which is why the load-modify-store ops pass through load.
//   A new item may be started in the cycle its predecessor's result is shown.
// Reset (synchronous, active low) makes task 0 current and clears ready,
//   killed and the valid bits of the per-task stores, so every stored word
//   reads as zero until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module task_switch_scheduler_top
    import tss_pkg::*;
#(
    parameter int NUM_TASKS = TSS_NUM_TASKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TSS_OP_W-1:0]   i_op,
    input  logic [TSS_WORD_W-1:0] i_psp_in,
    input  logic [TSS_WORD_W-1:0] i_event_mask,
    input  logic [TSS_TGT_W-1:0]  i_target_task,
    input  logic [TSS_WORD_W-1:0] i_reason_bits,
    input  logic [TSS_WORD_W-1:0] i_flag_bits,
    input  logic                  i_ready_in,
    input  logic                  i_killed_in,
    output logic                  o_done,
    output logic [TSS_CUR_W-1:0]  o_cur_task,
    output logic [TSS_WORD_W-1:0] o_psp_out,
    output logic [TSS_WORD_W-1:0] o_wake_reason
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int XW = IW + TSS_TGT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_LOAD
    } t_state;

    t_state r_state;

    // latched item
    t_op                   r_op;
    logic [TSS_WORD_W-1:0] r_psp;
    logic [TSS_WORD_W-1:0] r_mask;
    logic [TSS_TGT_W-1:0]  r_tgt;
    logic [TSS_WORD_W-1:0] r_rsn;
    logic [TSS_WORD_W-1:0] r_flg;
    logic                  r_rdy;
    logic                  r_kil;

    logic [IW-1:0]         r_cur;
    logic [IW:0]           r_scan;
    logic [NUM_TASKS-1:0]  r_ready;
    logic [NUM_TASKS-1:0]  r_killed;
    logic [NUM_TASKS-1:0]  r_psp_vld;
    logic [NUM_TASKS-1:0]  r_rsn_vld;
    logic [NUM_TASKS-1:0]  r_flg_vld;

    // per-task word stores
    logic [TSS_WORD_W-1:0] psp_mem  [NUM_TASKS];
    logic [TSS_WORD_W-1:0] rsn_mem  [NUM_TASKS];
    logic [TSS_WORD_W-1:0] flg_mem  [NUM_TASKS];
    logic [TSS_WORD_W-1:0] mask_mem [NUM_TASKS];

    logic [TSS_WORD_W-1:0] r_psp_rd;
    logic [TSS_WORD_W-1:0] r_rsn_rd;
    logic [TSS_WORD_W-1:0] r_flg_rd;
    logic                  r_psp_rv;
    logic                  r_rsn_rv;
    logic                  r_flg_rv;

    logic                  r_done;
    logic [TSS_WORD_W-1:0] r_psp_o;
    logic [TSS_WORD_W-1:0] r_rsn_o;

    // control of the stores
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  psp_we;
    logic                  rsn_we;
    logic                  flg_we;
    logic                  mask_we;
    logic [IW-1:0]         wr_addr;
    logic [TSS_WORD_W-1:0] psp_wd;
    logic [TSS_WORD_W-1:0] rsn_wd;
    logic [TSS_WORD_W-1:0] flg_wd;

    logic                  accept;
    logic [XW-1:0]         tgt_ext;
    logic [IW-1:0]         tgt_idx;
    logic                  tgt_ok;
    logic                  act_ok;
    logic                  scan_end;
    logic                  scan_hit;
    logic                  scan_found;
    logic [IW-1:0]         scan_idx;
    logic [IW-1:0]         pick;
    logic [XW-1:0]         cur_ext;
    logic [TSS_WORD_W-1:0] rsn_old;
    logic [TSS_WORD_W-1:0] flg_old;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);

    assign tgt_ext = {{IW{1'b0}}, r_tgt};
    assign tgt_idx = tgt_ext[IW-1:0];
    assign tgt_ok  = (tgt_ext < XW'(NUM_TASKS));
    assign act_ok  = tgt_ok && !r_killed[tgt_idx];

    // one slot tested per cycle; reaching the top of the table means idle
    assign scan_end   = (r_scan == (IW+1)'(NUM_TASKS));
    assign scan_idx   = r_scan[IW-1:0];
    assign scan_hit   = !scan_end && r_ready[scan_idx] && !r_killed[scan_idx];
    assign scan_found = scan_end || scan_hit;
    assign pick       = scan_end ? '0 : scan_idx;

    assign rsn_old = r_rsn_rv ? r_rsn_rd : '0;
    assign flg_old = r_flg_rv ? r_flg_rd : '0;

    assign cur_ext = {{TSS_TGT_W{1'b0}}, r_cur};

    assign o_done         = r_done;
    assign o_cur_task     = cur_ext[TSS_CUR_W-1:0];
    assign o_psp_out      = r_psp_o;
    assign o_wake_reason  = r_rsn_o;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cur;
        psp_we  = 1'b0;
        rsn_we  = 1'b0;
        flg_we  = 1'b0;
        mask_we = 1'b0;
        wr_addr = r_cur;
        psp_wd  = r_psp;
        rsn_wd  = rsn_old | r_rsn;
        flg_wd  = flg_old | r_flg;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    OP_SWITCH: begin
                        psp_we = 1'b1;
                    end
                    OP_WAIT: begin
                        mask_we = 1'b1;
                        rd_en   = 1'b1;
                    end
                    OP_ACTIVATE: begin
                        rd_en   = act_ok;
                        rd_addr = tgt_idx;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                rd_en   = scan_found;
                rd_addr = pick;
            end
            S_LOAD: begin
                if (r_op == OP_ACTIVATE) begin
                    rsn_we  = 1'b1;
                    flg_we  = 1'b1;
                    wr_addr = tgt_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // stores: one write each, one shared registered read for psp, reason, flag
    always_ff @(posedge i_clk) begin
        if (psp_we) begin
            psp_mem[wr_addr] <= psp_wd;
        end
        if (rsn_we) begin
            rsn_mem[wr_addr] <= rsn_wd;
        end
        if (flg_we) begin
            flg_mem[wr_addr] <= flg_wd;
        end
        if (mask_we) begin
            mask_mem[wr_addr] <= r_mask;
        end
        if (rd_en) begin
            r_psp_rd <= psp_mem[rd_addr];
            r_rsn_rd <= rsn_mem[rd_addr];
            r_flg_rd <= flg_mem[rd_addr];
            r_psp_rv <= r_psp_vld[rd_addr];
            r_rsn_rv <= r_rsn_vld[rd_addr];
            r_flg_rv <= r_flg_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_psp  <= i_psp_in;
            r_mask <= i_event_mask;
            r_tgt  <= i_target_task;
            r_rsn  <= i_reason_bits;
            r_flg  <= i_flag_bits;
            r_rdy  <= i_ready_in;
            r_kil  <= i_killed_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_scan    <= '0;
            r_ready   <= '0;
            r_killed  <= '0;
            r_psp_vld <= '0;
            r_rsn_vld <= '0;
            r_flg_vld <= '0;
            r_done    <= 1'b0;
            r_psp_o   <= '0;
            r_rsn_o   <= '0;
        end else begin
            if (psp_we) begin
                r_psp_vld[wr_addr] <= 1'b1;
            end
            if (rsn_we) begin
                r_rsn_vld[wr_addr] <= 1'b1;
            end
            if (flg_we) begin
                r_flg_vld[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    // every item passes through idle, which ends the strobe
                    r_done <= 1'b0;
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_SWITCH: begin
                            r_scan  <= {1'b0, r_cur} + (IW+1)'(1);
                            r_state <= S_SCAN;
                        end
                        OP_WAIT: begin
                            r_ready[r_cur] <= 1'b0;
                            r_state        <= S_LOAD;
                        end
                        OP_ACTIVATE: begin
                            if (act_ok) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_psp_o <= '0;
                                r_rsn_o <= '0;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            if (tgt_ok) begin
                                r_ready[tgt_idx]  <= r_rdy;
                                r_killed[tgt_idx] <= r_kil;
                            end
                            r_psp_o <= '0;
                            r_rsn_o <= '0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (scan_found) begin
                        r_cur   <= pick;
                        r_state <= S_LOAD;
                    end else begin
                        r_scan <= r_scan + (IW+1)'(1);
                    end
                end
                S_LOAD: begin
                    case (r_op)
                        OP_SWITCH: begin
                            r_psp_o <= r_psp_rv ? r_psp_rd : '0;
                            r_rsn_o <= '0;
                        end
                        OP_WAIT: begin
                            // reason handed out, then reads as zero
                            r_psp_o          <= '0;
                            r_rsn_o          <= rsn_old;
                            r_rsn_vld[r_cur] <= 1'b0;
                        end
                        OP_ACTIVATE: begin
                            r_psp_o           <= '0;
                            r_rsn_o           <= '0;
                            r_ready[tgt_idx]  <= 1'b1;
                            r_killed[tgt_idx] <= 1'b0;
                        end
                        default: begin
                            r_psp_o <= '0;
                            r_rsn_o <= '0;
                        end
                    endcase
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_done)
        else $error("accepted item did not raise busy");

    a_psp_only_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_op != OP_SWITCH) |-> (o_psp_out == '0))
        else $error("stack pointer returned for an op other than switch");

    a_rsn_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_op != OP_WAIT) |-> (o_wake_reason == '0))
        else $error("wakeup reason returned for an op other than wait");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan != '0) && (r_scan <= (IW+1)'(NUM_TASKS)))
        else $error("scan index left the task table");

endmodule

@@ sim/task_switch_scheduler_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_switch_scheduler_checker
// Watches the command and result ports of the task switch scheduler, keeps its
// own copy of the per-task state, predicts the result of every accepted item
// and compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module task_switch_scheduler_checker
    import tss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [TSS_OP_W-1:0]   i_op,
    input  logic [TSS_WORD_W-1:0] i_psp_in,
    input  logic [TSS_WORD_W-1:0] i_event_mask,
    input  logic [TSS_TGT_W-1:0]  i_target_task,
    input  logic [TSS_WORD_W-1:0] i_reason_bits,
    input  logic [TSS_WORD_W-1:0] i_flag_bits,
    input  logic                  i_ready_in,
    input  logic                  i_killed_in,
    input  logic                  i_done,
    input  logic [TSS_CUR_W-1:0]  i_cur_task,
    input  logic [TSS_WORD_W-1:0] i_psp_out,
    input  logic [TSS_WORD_W-1:0] i_wake_reason,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic [TSS_CUR_W-1:0]  cur_task;
        logic [TSS_WORD_W-1:0] stack_ptr;
        logic [TSS_WORD_W-1:0] reason;
    } sched_result_t;

    // scheduler state as the block should hold it
    int                    run_id;
    logic [TSS_WORD_W-1:0] saved_psp   [TSS_NUM_TASKS];
    logic                  task_ready  [TSS_NUM_TASKS];
    logic                  task_killed [TSS_NUM_TASKS];
    logic [TSS_WORD_W-1:0] wait_mask   [TSS_NUM_TASKS];
    logic [TSS_WORD_W-1:0] wake_reason [TSS_NUM_TASKS];
    logic [TSS_WORD_W-1:0] wake_flag   [TSS_NUM_TASKS];

    sched_result_t sched_results_q[$];
    int            fails   = 0;
    int            checked = 0;

    initial begin
        run_id       = 0;
        for (int i = 0; i < TSS_NUM_TASKS; i++) begin
            saved_psp[i]   = '0;
            task_ready[i]  = 1'b0;
            task_killed[i] = 1'b0;
            wait_mask[i]   = '0;
            wake_reason[i] = '0;
            wake_flag[i]   = '0;
        end
    end

    function automatic sched_result_t schedule_item(
        input t_op                   op,
        input logic [TSS_WORD_W-1:0] psp,
        input logic [TSS_WORD_W-1:0] mask,
        input logic [TSS_TGT_W-1:0]  tgt,
        input logic [TSS_WORD_W-1:0] rsn,
        input logic [TSS_WORD_W-1:0] flg,
        input logic                  rdy,
        input logic                  kil
    );
        sched_result_t res;
        int            cur;
        int            next_id;
        res = '0;
        cur = run_id % TSS_NUM_TASKS;
        case (op)
            OP_SWITCH: begin
                saved_psp[cur] = psp;
                next_id = 0;
                // first ready, live task above the current one; the scan never wraps
                for (int id = cur + 1; id < TSS_NUM_TASKS; id++) begin
                    if (next_id == 0 && task_ready[id] && !task_killed[id])
                        next_id = id;
                end
                run_id = next_id;
                res.stack_ptr = saved_psp[next_id];
            end
            OP_WAIT: begin
                wait_mask[cur]   = mask;
                task_ready[cur]  = 1'b0;
                res.reason       = wake_reason[cur];
                wake_reason[cur] = '0;
            end
            OP_ACTIVATE: begin
                if (int'(tgt) < TSS_NUM_TASKS && !task_killed[tgt]) begin
                    wake_reason[tgt] = wake_reason[tgt] | rsn;
                    wake_flag[tgt]   = wake_flag[tgt] | flg;
                    task_ready[tgt]  = 1'b1;
                end
            end
            default: begin
                if (int'(tgt) < TSS_NUM_TASKS) begin
                    task_ready[tgt]  = rdy;
                    task_killed[tgt] = kil;
                end
            end
        endcase
        res.cur_task = run_id[TSS_CUR_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_ports
        sched_result_t want;
        if (i_rst_n) begin
            if (i_done) begin
                if (sched_results_q.size() == 0) begin
                    $error("result strobed with no item outstanding");
                    fails++;
                end else begin
                    want = sched_results_q.pop_front();
                    checked++;
                    if (i_cur_task !== want.cur_task) begin
                        $error("cur_task: expected %0d, got %0d",
                               want.cur_task, i_cur_task);
                        fails++;
                    end
                    if (i_psp_out !== want.stack_ptr) begin
                        $error("psp_out: expected %08h, got %08h",
                               want.stack_ptr, i_psp_out);
                        fails++;
                    end
                    if (i_wake_reason !== want.reason) begin
                        $error("wake_reason: expected %08h, got %08h",
                               want.reason, i_wake_reason);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy)
                sched_results_q.push_back(schedule_item(t_op'(i_op), i_psp_in,
                    i_event_mask, i_target_task, i_reason_bits, i_flag_bits,
                    i_ready_in, i_killed_in));
        end
        o_pending    <= sched_results_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

@@ sim/task_switch_scheduler_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_switch_scheduler_top_test
// Drives the task switch scheduler with a directed run through switch, wait,
// activate and set_state corner cases, then with random op mixes and random
// start gaps; the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module task_switch_scheduler_top_test;
    import tss_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 24;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    t_op                   i_op          = OP_SWITCH;
    logic [TSS_WORD_W-1:0] i_psp_in      = '0;
    logic [TSS_WORD_W-1:0] i_event_mask  = '0;
    logic [TSS_TGT_W-1:0]  i_target_task = '0;
    logic [TSS_WORD_W-1:0] i_reason_bits = '0;
    logic [TSS_WORD_W-1:0] i_flag_bits   = '0;
    logic                  i_ready_in    = 1'b0;
    logic                  i_killed_in   = 1'b0;
    logic                  o_done;
    logic [TSS_CUR_W-1:0]  o_cur_task;
    logic [TSS_WORD_W-1:0] o_psp_out;
    logic [TSS_WORD_W-1:0] o_wake_reason;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int burst_left = 0;
    int sent_by_op[4] = '{0, 0, 0, 0};

    always #5 i_clk = ~i_clk;

    task_switch_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_psp_in       (i_psp_in),
        .i_event_mask   (i_event_mask),
        .i_target_task  (i_target_task),
        .i_reason_bits  (i_reason_bits),
        .i_flag_bits    (i_flag_bits),
        .i_ready_in     (i_ready_in),
        .i_killed_in    (i_killed_in),
        .o_done         (o_done),
        .o_cur_task     (o_cur_task),
        .o_psp_out      (o_psp_out),
        .o_wake_reason  (o_wake_reason)
    );

    task_switch_scheduler_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_psp_in       (i_psp_in),
        .i_event_mask   (i_event_mask),
        .i_target_task  (i_target_task),
        .i_reason_bits  (i_reason_bits),
        .i_flag_bits    (i_flag_bits),
        .i_ready_in     (i_ready_in),
        .i_killed_in    (i_killed_in),
        .i_done         (o_done),
        .i_cur_task     (o_cur_task),
        .i_psp_out      (o_psp_out),
        .i_wake_reason  (o_wake_reason),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always @(posedge i_clk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            cycles <= cycles + 1;
        end
    end

    // holds start high until the block takes the item
    task automatic send_item(
        input t_op                   op,
        input logic [TSS_WORD_W-1:0] psp,
        input logic [TSS_WORD_W-1:0] mask,
        input logic [TSS_TGT_W-1:0]  tgt,
        input logic [TSS_WORD_W-1:0] rsn,
        input logic [TSS_WORD_W-1:0] flg,
        input logic                  rdy,
        input logic                  kil
    );
        start         <= 1'b1;
        i_op          <= op;
        i_psp_in      <= psp;
        i_event_mask  <= mask;
        i_target_task <= tgt;
        i_reason_bits <= rsn;
        i_flag_bits   <= flg;
        i_ready_in    <= rdy;
        i_killed_in   <= kil;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_by_op[op]++;
    endtask

    // mostly back to back or short gaps, now and then a long one
    task automatic idle_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if (r < 3) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
        end else if (r < 45) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [TSS_WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic send_random_item();
        int   r;
        t_op  op;
        logic kil;
        r = $urandom_range(0, 99);
        if (r < 30)
            op = OP_SWITCH;
        else if (r < 48)
            op = OP_WAIT;
        else if (r < 80)
            op = OP_ACTIVATE;
        else
            op = OP_SET_STATE;
        // kills are kept rare so that enough tasks stay schedulable
        kil = ($urandom_range(0, 3) == 0);
        send_item(op, pick_word(), pick_word(), TSS_TGT_W'($urandom_range(0, 7)),
                  pick_word(), pick_word(), 1'($urandom), kil);
        idle_sender();
    endtask

    task automatic directed_item(
        input t_op                   op,
        input logic [TSS_WORD_W-1:0] psp,
        input logic [TSS_TGT_W-1:0]  tgt,
        input logic [TSS_WORD_W-1:0] rsn,
        input logic                  rdy,
        input logic                  kil
    );
        send_item(op, psp, ~psp, tgt, rsn, ~rsn, rdy, kil);
        idle_sender();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing ready: switches stay on the idle task
        directed_item(OP_SWITCH,    32'h0000_0000, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'hFFFF_FFFF, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_WAIT,      32'h0000_0000, 3'd0, 32'h0,          1'b0, 1'b0);
        // wait on the idle task hands back its reasons
        directed_item(OP_ACTIVATE,  32'h0000_0000, 3'd0, 32'hA5A5_A5A5,  1'b0, 1'b0);
        directed_item(OP_WAIT,      32'hFFFF_FFFF, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_ACTIVATE,  32'h0000_0000, 3'd7, 32'hFFFF_FFFF,  1'b0, 1'b0);
        directed_item(OP_ACTIVATE,  32'h0000_0000, 3'd3, 32'h0000_0001,  1'b0, 1'b0);
        // activate of a killed task is dropped
        directed_item(OP_SET_STATE, 32'h0000_0000, 3'd5, 32'h0,          1'b1, 1'b1);
        directed_item(OP_ACTIVATE,  32'h0000_0000, 3'd5, 32'h8000_0000,  1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'h1234_5678, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_WAIT,      32'h8000_0001, 3'd0, 32'h0,          1'b0, 1'b0);
        // ready but killed slot is skipped by the scan
        directed_item(OP_SWITCH,    32'hDEAD_BEEF, 3'd0, 32'h0,          1'b0, 1'b0);
        // top slot: scan runs out and falls back to idle
        directed_item(OP_SWITCH,    32'h8000_0000, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'h0000_0001, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SET_STATE, 32'h0000_0000, 3'd7, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SET_STATE, 32'h0000_0000, 3'd5, 32'h0,          1'b1, 1'b0);
        directed_item(OP_SWITCH,    32'h7FFF_FFFF, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'h5555_5555, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SET_STATE, 32'h0000_0000, 3'd1, 32'h0,          1'b1, 1'b0);
        directed_item(OP_SWITCH,    32'hAAAA_AAAA, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'h0F0F_0F0F, 3'd0, 32'h0,          1'b0, 1'b0);
        // killing the idle task does not stop the fallback to it
        directed_item(OP_SET_STATE, 32'h0000_0000, 3'd0, 32'h0,          1'b0, 1'b1);
        directed_item(OP_ACTIVATE,  32'h0000_0000, 3'd0, 32'hFFFF_FFFF,  1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'hF0F0_F0F0, 3'd0, 32'h0,          1'b0, 1'b0);
        directed_item(OP_SWITCH,    32'h0000_0000, 3'd0, 32'h0,          1'b0, 1'b0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_item();
            if (n % 300 == 150)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d switches, %0d waits, %0d activates, %0d state writes",
                 sent_by_op[OP_SWITCH], sent_by_op[OP_WAIT],
                 sent_by_op[OP_ACTIVATE], sent_by_op[OP_SET_STATE]);
        $display("%0d results compared, %0d field errors", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ task_switch_scheduler_top.f @@
rtl/tss_pkg.sv
rtl/task_switch_scheduler_top.sv
sim/task_switch_scheduler_checker.sv
sim/task_switch_scheduler_top_test.sv
